// ===== design/led_matrix_frame_buffer_scanout_macros.svh =====
// ----------------------------------------------------------------------------
// LED matrix scanout assertion macros
// Shared same-cycle and next-cycle implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_FRAME_BUFFER_SCANOUT_MACROS_SVH
`define LED_MATRIX_FRAME_BUFFER_SCANOUT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LMFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define LMFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lmfb_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfb_pkg
// Types, sizes and lookup tables for the LED matrix frame buffer scanout.
// ----------------------------------------------------------------------------
package lmfb_pkg;

    localparam int SEGMENTS = 4;                 // cascaded 8x8 segments, 1..8
    localparam int SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int ADDR_W   = SEG_W + 3;         // {segment, row}
    localparam int DEPTH    = 8 * SEGMENTS;
    localparam int FILL_W   = 6;
    localparam int PIX_W    = ($clog2(8 * SEGMENTS + 1) > FILL_W) ?
                              $clog2(8 * SEGMENTS + 1) : FILL_W;

    localparam logic [SEG_W-1:0] SEG_MAX  = SEG_W'(SEGMENTS - 1);
    localparam logic [PIX_W-1:0] FULL_PIX = PIX_W'(8 * SEGMENTS);

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_BAR   = 2'd1,
        KIND_SHOW  = 2'd2,
        KIND_BCAST = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // segment number for each value of column[7:3]
    typedef logic [SEG_W-1:0] t_seg_lut [32];

    function automatic t_seg_lut build_seg_lut();
        t_seg_lut lut;
        for (int i = 0; i < 32; i++) begin
            lut[i] = SEG_W'(i % SEGMENTS);
        end
        return lut;
    endfunction

    localparam t_seg_lut SEG_OF_COL = build_seg_lut();

endpackage

// ===== design/led_matrix_frame_buffer_scanout.sv =====
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer_scanout
// Frame store and register-write sequencer for cascaded 8x8 LED segments.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. The
//   kind field picks set pixel, progress bar, show-and-clear or broadcast.
//   busy stays high until the last store access or broadcast step; the final
//   result of a request is flagged in the first cycle with busy low.
//   Results are register writes for the segment drivers. Each one is on the
//   o_ result ports for exactly one cycle, flagged by o_strobe; the receiver
//   cannot stall, so nothing waits and nothing is dropped.
// Steps (S = segments, one store byte per cycle through the shared unit):
//   set pixel    : one read-modify-write of the pixel's byte, no results
//   progress bar : all segments per bar row, no results, none at zero height
//   show         : results come one per cycle through the read-modify-write
//                  stage and result register, rows 0..7, last segment of
//                  each row first, store cleared as it is read
//   broadcast    : S results one per cycle from the result register
//   The frame store port (one read, one write per cycle) sets this rate.
// Reset: the frame store reads as all zero (per-byte valid flags), the
//   sequencer goes idle, no result is flagged.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_scanout (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [2:0] i_row,
    input  logic [7:0] i_column,
    input  logic [3:0] i_bar_height,
    input  logic [5:0] i_fill_pixels,
    input  logic [3:0] i_cmd_address,
    input  logic [7:0] i_cmd_data,
    output logic       o_strobe,
    output logic [3:0] o_reg_address,
    output logic [7:0] o_reg_data,
    output logic       o_select_release,
    output logic       o_last
);

`include "led_matrix_frame_buffer_scanout_macros.svh"

    localparam int ADDR_W = lmfb_pkg::ADDR_W;
    localparam int SEG_W  = lmfb_pkg::SEG_W;
    localparam int PIX_W  = lmfb_pkg::PIX_W;

    // ---------------- sequencer state ----------------
    lmfb_pkg::t_state r_state, n_state;
    logic [2:0]       r_row, n_row;
    logic [SEG_W-1:0] r_seg, n_seg;

    // request fields held for the whole request
    lmfb_pkg::t_kind  r_kind;
    logic [2:0]       r_last_row;
    logic [PIX_W-1:0] r_fill;
    logic [7:0]       r_pix_mask;
    logic [3:0]       r_cmd_address;
    logic [7:0]       r_cmd_data;

    logic             accept;
    logic             issue;     // read one store byte this cycle
    logic             bc_emit;   // emit one broadcast write this cycle
    logic [4:0]       bar_end;
    logic [2:0]       bar_last;
    logic [PIX_W-1:0] fill_sat;

    assign accept = start && !busy;
    assign busy   = (r_state != lmfb_pkg::ST_IDLE);

    assign bar_end  = {2'b00, i_row} + {1'b0, i_bar_height};
    assign bar_last = (bar_end >= 5'd8) ? 3'd7 : 3'(bar_end - 5'd1);
    assign fill_sat = (PIX_W'(i_fill_pixels) > lmfb_pkg::FULL_PIX) ?
                      lmfb_pkg::FULL_PIX : PIX_W'(i_fill_pixels);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmfb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_seg <= n_seg;
        if (accept) begin
            r_kind        <= lmfb_pkg::t_kind'(i_kind);
            r_last_row    <= bar_last;
            r_fill        <= fill_sat;
            r_pix_mask    <= 8'd1 << i_column[2:0];
            r_cmd_address <= i_cmd_address;
            r_cmd_data    <= i_cmd_data;
        end
    end

    // next state and step control
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_seg   = r_seg;
        issue   = 1'b0;
        bc_emit = 1'b0;
        unique case (r_state)
            lmfb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lmfb_pkg::ST_RUN;
                    n_row   = i_row;
                    n_seg   = '0;
                    unique case (lmfb_pkg::t_kind'(i_kind))
                        lmfb_pkg::KIND_PIXEL: begin
                            n_seg = lmfb_pkg::SEG_OF_COL[i_column[7:3]];
                        end
                        lmfb_pkg::KIND_BAR: begin
                            if (i_bar_height == 4'd0) begin
                                n_state = lmfb_pkg::ST_IDLE;
                            end
                        end
                        lmfb_pkg::KIND_SHOW: begin
                            n_row = 3'd0;
                            n_seg = lmfb_pkg::SEG_MAX;
                        end
                        default: begin
                            n_seg = '0;
                        end
                    endcase
                end
            end
            lmfb_pkg::ST_RUN: begin
                unique case (r_kind)
                    lmfb_pkg::KIND_BCAST: begin
                        bc_emit = 1'b1;
                        if (r_seg == lmfb_pkg::SEG_MAX) begin
                            n_state = lmfb_pkg::ST_IDLE;
                        end else begin
                            n_seg = r_seg + 1'b1;
                        end
                    end
                    lmfb_pkg::KIND_PIXEL: begin
                        issue   = 1'b1;
                        n_state = lmfb_pkg::ST_DRAIN;
                    end
                    lmfb_pkg::KIND_BAR: begin
                        issue = 1'b1;
                        if (r_seg == lmfb_pkg::SEG_MAX) begin
                            n_seg = '0;
                            if (r_row == r_last_row) begin
                                n_state = lmfb_pkg::ST_DRAIN;
                            end else begin
                                n_row = r_row + 3'd1;
                            end
                        end else begin
                            n_seg = r_seg + 1'b1;
                        end
                    end
                    default: begin   // show: last segment first in each row
                        issue = 1'b1;
                        if (r_seg == '0) begin
                            n_seg = lmfb_pkg::SEG_MAX;
                            if (r_row == 3'd7) begin
                                n_state = lmfb_pkg::ST_DRAIN;
                            end else begin
                                n_row = r_row + 3'd1;
                            end
                        end else begin
                            n_seg = r_seg - 1'b1;
                        end
                    end
                endcase
            end
            lmfb_pkg::ST_DRAIN: begin
                n_state = lmfb_pkg::ST_IDLE;
            end
            default: begin
                n_state = lmfb_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- shared mask unit ----------------
    // One subtract and compare per byte: pixels left for this segment.
    logic [PIX_W-1:0] seg_base;
    logic [PIX_W-1:0] pix_left;
    logic [7:0]       bar_mask;
    logic [7:0]       step_mask;

    assign seg_base = PIX_W'({r_seg, 3'b000});
    assign pix_left = r_fill - seg_base;

    always_comb begin
        if (r_fill <= seg_base) begin
            bar_mask = 8'h00;
        end else if (pix_left >= PIX_W'(8)) begin
            bar_mask = 8'hFF;
        end else begin
            bar_mask = (8'h01 << pix_left[2:0]) - 8'h01;
        end
    end

    assign step_mask = (r_kind == lmfb_pkg::KIND_PIXEL) ? r_pix_mask : bar_mask;

    // ---------------- frame store ----------------
    logic [7:0]        r_mem [lmfb_pkg::DEPTH];
    logic [lmfb_pkg::DEPTH-1:0] r_valid;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        r_rdata;
    logic              r_rvalid;

    // read-modify-write stage
    logic              r_rd_vld;
    logic              r_rd_show;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [7:0]        r_rd_mask;
    logic [2:0]        r_rd_row;
    logic [SEG_W-1:0]  r_rd_seg;
    logic [7:0]        cur_byte;
    logic [7:0]        wr_data;

    assign rd_addr  = {r_seg, r_row};
    assign cur_byte = r_rvalid ? r_rdata : 8'h00;
    assign wr_data  = r_rd_show ? 8'h00 : (cur_byte | r_rd_mask);

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (r_rd_vld) begin
            r_mem[r_rd_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (r_rd_vld) begin
                r_valid[r_rd_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rvalid  <= r_valid[rd_addr];
            r_rd_show <= (r_kind == lmfb_pkg::KIND_SHOW);
            r_rd_addr <= rd_addr;
            r_rd_mask <= step_mask;
            r_rd_row  <= r_row;
            r_rd_seg  <= r_seg;
        end
    end

    // ---------------- result register ----------------
    logic       r_strobe;
    logic [3:0] r_reg_address;
    logic [7:0] r_reg_data;
    logic       r_select_release;
    logic       r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= bc_emit || (r_rd_vld && r_rd_show);
        end
    end

    always_ff @(posedge i_clk) begin
        if (bc_emit) begin
            r_reg_address    <= r_cmd_address;
            r_reg_data       <= r_cmd_data;
            r_select_release <= (r_seg == lmfb_pkg::SEG_MAX);
            r_last           <= (r_seg == lmfb_pkg::SEG_MAX);
        end else begin
            // row r goes to driver register 1 + (7 - r)
            r_reg_address    <= 4'd8 - {1'b0, r_rd_row};
            r_reg_data       <= cur_byte;
            r_select_release <= (r_rd_seg == '0);
            r_last           <= (r_rd_seg == '0) && (r_rd_row == 3'd7);
        end
    end

    assign o_strobe         = r_strobe;
    assign o_reg_address    = r_reg_address;
    assign o_reg_data       = r_reg_data;
    assign o_select_release = r_select_release;
    assign o_last           = r_last;

    // ---------------- assertions ----------------
    `LMFB_ASSERT_NOW(a_last_releases, o_strobe && o_last, o_select_release,
        "final write of a request must release chip select")
    `LMFB_ASSERT_NOW(a_last_ends_busy, o_strobe && o_last, !busy,
        "sequencer still busy on the final write")
    `LMFB_ASSERT_NOW(a_write_while_busy, r_rd_vld, busy,
        "store write pending while idle")
    `LMFB_ASSERT_NEXT(a_no_stray_result, accept, !o_strobe,
        "result flagged right after a new request")

endmodule
